>>> hdl/llss_pkg.sv
package llss_pkg;

  // Position width and derived field widths
  localparam int PosBits     = 12;
  localparam int WinBits     = 2 * PosBits;
  localparam int SumBits     = PosBits + 1;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = WinBits;

  // Steering magnitude lookup: address is |x| clamped, data is Q2.8 magnitude
  localparam int AddrBits  = 10;
  localparam int RomDepth  = 2 ** AddrBits;
  localparam int MagBits   = 10;
  localparam int SteerBits = 11;
  localparam int SatLimit  = 333;

  typedef enum logic [1:0] {
    SEL_RIGHT = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_MID   = 2'd2,
    SEL_STOP  = 2'd3
  } sel_state_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_RIGHT_WIN = 3'd0,
    CFG_LEFT_WIN  = 3'd1,
    CFG_MID_WIN   = 3'd2,
    CFG_RIGHT_OFS = 3'd3,
    CFG_LEFT_OFS  = 3'd4,
    CFG_MID_OFS   = 3'd5,
    CFG_SAT_EN    = 3'd6
  } cfg_idx_t;

  typedef logic [MagBits-1:0] mag_rom_t [RomDepth];

  // exp(-2^i/100) in Q0.32, one factor per address bit
  localparam logic [31:0] ExpFactor [AddrBits] = '{
    32'd4252231657, 32'd4209921246, 32'd4126559220, 32'd3964754518,
    32'd3659929705, 32'd3118786366, 32'd2264703717, 32'd1194161113,
    32'd332021332,  32'd25666823
  };

  // Build the magnitude table 768*(1-exp(-a/100)) at elaboration
  function automatic mag_rom_t build_mag_rom();
    mag_rom_t    rom;
    logic [63:0] e;
    logic [63:0] m;
    for (int a = 0; a < RomDepth; a++) begin
      e = 64'h1_0000_0000;
      for (int i = 0; i < AddrBits; i++) begin
        if (a[i]) begin
          e = (e * {32'd0, ExpFactor[i]} + 64'h8000_0000) >> 32;
        end
      end
      m = (64'd768 * (64'h1_0000_0000 - e) + 64'h8000_0000) >> 32;
      rom[a] = m[MagBits-1:0];
    end
    return rom;
  endfunction

  // Lowest address whose magnitude reaches the snap limit (table is monotonic)
  function automatic logic [AddrBits-1:0] find_sat_addr(mag_rom_t rom);
    logic [AddrBits-1:0] addr;
    addr = AddrBits'(RomDepth - 1);
    for (int a = RomDepth - 1; a >= 0; a--) begin
      if (int'(rom[a]) >= SatLimit) begin
        addr = AddrBits'(a);
      end
    end
    return addr;
  endfunction

  localparam mag_rom_t            MagRom  = build_mag_rom();
  localparam logic [AddrBits-1:0] SatAddr = find_sat_addr(MagRom);

endpackage

>>> hdl/llss_in_if.sv
interface llss_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [llss_pkg::PosBits-1:0] mid_pos;
  logic signed [llss_pkg::PosBits-1:0] right_pos;
  logic signed [llss_pkg::PosBits-1:0] left_pos;

  modport source (output valid, mid_pos, right_pos, left_pos, input ready);
  modport sink   (input valid, mid_pos, right_pos, left_pos, output ready);
endinterface

>>> hdl/llss_out_if.sv
interface llss_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [llss_pkg::SteerBits-1:0] steering;
  logic                                   no_line;
  logic [1:0]                             line_choice;

  modport source (output valid, steering, no_line, line_choice, input ready);
  modport sink   (input valid, steering, no_line, line_choice, output ready);
endinterface

>>> hdl/lane_line_select_steering_unit.sv
// A beat passes two registers: stage 1 holds the table address, and stage 2 reads
// the magnitude table into the result register.
// Throughput: one beat per cycle; back-pressure stalls both stages.
// Input ready falls only when both stages are full and the output is not taken.
// Reset (rst_n low, synchronous): selector on the right line, held position and
// offset zero, line lost set, windows and offsets zero, saturation enabled.
module lane_line_select_steering_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  llss_in_if.sink                            in_beat,
  llss_out_if.source                         out_beat,
  input  logic                               cfg_wr_en,
  input  logic [llss_pkg::CfgIdxBits-1:0]    cfg_index,
  input  logic [llss_pkg::CfgDataBits-1:0]   cfg_data
);

  localparam int P = llss_pkg::PosBits;

  // Configuration registers
  logic [llss_pkg::WinBits-1:0] right_win_r, left_win_r, mid_win_r;
  logic signed [P-1:0]          right_ofs_r, left_ofs_r, mid_ofs_r;
  logic                         sat_en_r;

  // Selector state
  llss_pkg::sel_state_t state_r, state_nxt;
  logic signed [P-1:0]  held_pos_r, held_pos_nxt;
  logic signed [P-1:0]  held_ofs_r, held_ofs_nxt;
  logic                 lost_r, lost_nxt;

  // Pipeline stages
  logic                          s1_valid_r;
  logic [llss_pkg::AddrBits-1:0] s1_addr_r, s1_addr_nxt;
  logic                          s1_neg_r, s1_lost_r;
  logic [1:0]                    s1_choice_r;
  logic                          out_valid_r;
  logic [llss_pkg::MagBits-1:0]  out_mag_r;
  logic                          out_neg_r, out_lost_r;
  logic [1:0]                    out_choice_r;

  logic accept, out_adv, s1_adv;
  logic r_ok, l_ok, m_ok;
  logic signed [llss_pkg::SumBits-1:0] x_sum;
  logic [llss_pkg::SumBits-1:0]        x_abs;
  logic signed [llss_pkg::SteerBits-1:0] mag_ext;

  // Window test: strictly between signed low and high bounds
  function automatic logic in_window(logic signed [P-1:0] v,
                                     logic [llss_pkg::WinBits-1:0] win);
    logic signed [P-1:0] lo;
    logic signed [P-1:0] hi;
    lo = $signed(win[P-1:0]);
    hi = $signed(win[2*P-1:P]);
    return (v > lo) && (v < hi);
  endfunction

  // Handshake: advance a stage when the one after it can take the beat
  assign out_adv       = !out_valid_r || out_beat.ready;
  assign s1_adv        = !s1_valid_r || out_adv;
  assign in_beat.ready = s1_adv;
  assign accept        = in_beat.valid && s1_adv;

  // Write configuration; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_win_r <= '0;
      left_win_r  <= '0;
      mid_win_r   <= '0;
      right_ofs_r <= '0;
      left_ofs_r  <= '0;
      mid_ofs_r   <= '0;
      sat_en_r    <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        llss_pkg::CFG_RIGHT_WIN: right_win_r <= cfg_data;
        llss_pkg::CFG_LEFT_WIN:  left_win_r  <= cfg_data;
        llss_pkg::CFG_MID_WIN:   mid_win_r   <= cfg_data;
        llss_pkg::CFG_RIGHT_OFS: right_ofs_r <= $signed(cfg_data[P-1:0]);
        llss_pkg::CFG_LEFT_OFS:  left_ofs_r  <= $signed(cfg_data[P-1:0]);
        llss_pkg::CFG_MID_OFS:   mid_ofs_r   <= $signed(cfg_data[P-1:0]);
        llss_pkg::CFG_SAT_EN:    sat_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign r_ok = in_window(in_beat.right_pos, right_win_r);
  assign l_ok = in_window(in_beat.left_pos, left_win_r);
  assign m_ok = in_window(in_beat.mid_pos, mid_win_r);

  // Selector next state: keep a valid left line, leave right when it fails; mid and stop go right, then left first
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      llss_pkg::SEL_RIGHT: begin
        if (!r_ok) state_nxt = llss_pkg::SEL_LEFT;
      end
      llss_pkg::SEL_LEFT: begin
        if (l_ok)      state_nxt = llss_pkg::SEL_LEFT;
        else if (r_ok) state_nxt = llss_pkg::SEL_RIGHT;
        else           state_nxt = llss_pkg::SEL_MID;
      end
      llss_pkg::SEL_MID: begin
        if (r_ok)      state_nxt = llss_pkg::SEL_RIGHT;
        else if (l_ok) state_nxt = llss_pkg::SEL_LEFT;
        else if (m_ok) state_nxt = llss_pkg::SEL_MID;
        else           state_nxt = llss_pkg::SEL_STOP;
      end
      default: begin
        if (r_ok)      state_nxt = llss_pkg::SEL_RIGHT;
        else if (l_ok) state_nxt = llss_pkg::SEL_LEFT;
        else if (m_ok) state_nxt = llss_pkg::SEL_MID;
        else           state_nxt = llss_pkg::SEL_STOP;
      end
    endcase
  end

  // Selector outputs: latch the followed line; in stop, clear position and offset and set line lost
  always_comb begin
    held_pos_nxt = held_pos_r;
    held_ofs_nxt = held_ofs_r;
    lost_nxt     = lost_r;
    case (state_r)
      llss_pkg::SEL_RIGHT: begin
        if (r_ok) begin
          held_pos_nxt = in_beat.right_pos;
          held_ofs_nxt = right_ofs_r;
          lost_nxt     = 1'b0;
        end
      end
      llss_pkg::SEL_LEFT: begin
        if (l_ok) begin
          held_pos_nxt = in_beat.left_pos;
          held_ofs_nxt = left_ofs_r;
          lost_nxt     = 1'b0;
        end
      end
      llss_pkg::SEL_MID: begin
        if (!r_ok && !l_ok && m_ok) begin
          held_pos_nxt = in_beat.mid_pos;
          held_ofs_nxt = mid_ofs_r;
          lost_nxt     = 1'b0;
        end
      end
      default: begin
        held_pos_nxt = '0;
        held_ofs_nxt = '0;
        lost_nxt     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= llss_pkg::SEL_RIGHT;
      held_pos_r <= '0;
      held_ofs_r <= '0;
      lost_r     <= 1'b1;
    end else if (accept) begin
      state_r    <= state_nxt;
      held_pos_r <= held_pos_nxt;
      held_ofs_r <= held_ofs_nxt;
      lost_r     <= lost_nxt;
    end
  end

  // Table address: |x| clamped, pushed to the top entry when snapping applies
  always_comb begin
    x_sum = llss_pkg::SumBits'(held_pos_nxt) + llss_pkg::SumBits'(held_ofs_nxt);
    x_abs = x_sum[llss_pkg::SumBits-1] ? llss_pkg::SumBits'(-x_sum)
                                       : llss_pkg::SumBits'(x_sum);
    if (x_abs > llss_pkg::SumBits'(llss_pkg::RomDepth - 1)) begin
      s1_addr_nxt = llss_pkg::AddrBits'(llss_pkg::RomDepth - 1);
    end else begin
      s1_addr_nxt = llss_pkg::AddrBits'(x_abs);
    end
    if (sat_en_r && (s1_addr_nxt >= llss_pkg::SatAddr)) begin
      s1_addr_nxt = llss_pkg::AddrBits'(llss_pkg::RomDepth - 1);
    end
  end

  // Stage 1: hold the table address and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r   <= s1_addr_nxt;
      s1_neg_r    <= !x_sum[llss_pkg::SumBits-1];
      s1_lost_r   <= lost_nxt;
      s1_choice_r <= state_nxt;
    end
  end

  // Stage 2: read the magnitude table into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_mag_r    <= llss_pkg::MagRom[s1_addr_r];
      out_neg_r    <= s1_neg_r;
      out_lost_r   <= s1_lost_r;
      out_choice_r <= s1_choice_r;
    end
  end

  // Apply sign and line-lost blanking to the result beat
  assign mag_ext = $signed({1'b0, out_mag_r});
  assign out_beat.valid       = out_valid_r;
  assign out_beat.steering    = out_lost_r ? '0 : (out_neg_r ? -mag_ext : mag_ext);
  assign out_beat.no_line     = out_lost_r;
  assign out_beat.line_choice = out_choice_r;

  // A step taken in stop always leaves the line lost
  a_stop_sets_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && state_r == llss_pkg::SEL_STOP) |=> lost_r)
    else $error("stop step did not raise line lost");

  // A stalled stage 1 keeps its beat and address
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(s1_addr_r)))
    else $error("stage 1 beat changed while stalled");

  // With snapping on, a magnitude is either below the limit or full scale
  a_snap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_en_r && !out_lost_r) |->
      (int'(out_mag_r) < llss_pkg::SatLimit || int'(out_mag_r) == 768))
    else $error("steering magnitude not snapped");

  // No line means zero steering
  a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat.valid && out_beat.no_line) |-> (out_beat.steering == '0))
    else $error("steering non-zero with no line");

endmodule
